// ----- rtl/core/position_grid_histogram_unit_defines.svh -----
// ---------------------------------------------------------------------------
// position grid histogram unit: assertion macros
// shared property forms for the histogram rtl, clocked on aclk, off in reset
// ---------------------------------------------------------------------------
`ifndef POSITION_GRID_HISTOGRAM_UNIT_DEFINES_SVH
`define POSITION_GRID_HISTOGRAM_UNIT_DEFINES_SVH

// same-cycle implication
`define PGH_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PGH_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pgh_pkg.sv -----
// ---------------------------------------------------------------------------
// pgh_pkg
// widths, codes and defaults shared by the position grid histogram rtl
// ---------------------------------------------------------------------------
package pgh_pkg;

    // field widths
    localparam int POS_W      = 25;  // signed degrees, 16 fraction bits
    localparam int SCALE_W    = 32;  // unsigned Q16.16 bins per degree
    localparam int SCALE_SH   = 32;  // bin = (diff * scale) >> 32
    localparam int USED_W     = 7;
    localparam int BIN_W      = 6;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // parameter defaults
    localparam int DEF_MAX_BINS_X = 64;
    localparam int DEF_MAX_BINS_Y = 64;
    localparam int DEF_COUNT_BITS = 20;

    // transaction modes
    typedef logic [MODE_W-1:0] mode_t;
    localparam mode_t MODE_ADD        = 2'd0;
    localparam mode_t MODE_READ       = 2'd1;
    localparam mode_t MODE_READ_CLEAR = 2'd2;

    // result status
    typedef enum logic [1:0] {
        ST_COUNTED = 2'd0,
        ST_DEAD    = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_READ    = 2'd3
    } status_t;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_LON_ORIGIN = 3'd0;
    localparam cfg_idx_t CFG_LAT_ORIGIN = 3'd1;
    localparam cfg_idx_t CFG_LON_SCALE  = 3'd2;
    localparam cfg_idx_t CFG_LAT_SCALE  = 3'd3;
    localparam cfg_idx_t CFG_X_USED     = 3'd4;
    localparam cfg_idx_t CFG_Y_USED     = 3'd5;

    // configuration reset values
    localparam logic signed [POS_W-1:0] RST_LON_ORIGIN = -25'sd393216;  // -6 deg
    localparam logic signed [POS_W-1:0] RST_LAT_ORIGIN = 25'sd1966080;  // 30 deg
    localparam logic [SCALE_W-1:0]      RST_LON_SCALE  = 32'd97541;
    localparam logic [SCALE_W-1:0]      RST_LAT_SCALE  = 32'd262144;
    localparam logic [USED_W-1:0]       RST_X_USED     = 7'd64;
    localparam logic [USED_W-1:0]       RST_Y_USED     = 7'd64;

    // per-axis stage controls
    typedef struct packed {
        logic load_diff;
        logic load_mul;
    } axis_ctl_t;

endpackage

// ----- rtl/core/pgh_axis.sv -----
// ---------------------------------------------------------------------------
// pgh_axis
// one axis of the binning path: origin subtract, scale multiply, range check
// ---------------------------------------------------------------------------
module pgh_axis #(
    parameter  int MAX_BINS = pgh_pkg::DEF_MAX_BINS_X,
    localparam int IDX_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
    input  logic                              aclk,
    input  pgh_pkg::axis_ctl_t                ctl,
    input  logic signed [pgh_pkg::POS_W-1:0]  pos,
    input  logic signed [pgh_pkg::POS_W-1:0]  origin,
    input  logic [pgh_pkg::SCALE_W-1:0]       scale,
    input  logic [pgh_pkg::USED_W-1:0]        used,
    output logic                              outside,
    output logic [IDX_W-1:0]                  bin
);
    import pgh_pkg::*;

    localparam int DIFF_W = POS_W + 1;
    localparam int PROD_W = POS_W + SCALE_W;
    localparam int QUO_W  = PROD_W - SCALE_SH;

    logic signed [DIFF_W-1:0] diff_reg;
    logic [PROD_W-1:0]        prod;
    logic [QUO_W-1:0]         quo_reg;
    logic                     neg_reg;

    // a nonnegative difference always fits in POS_W bits
    assign prod = diff_reg[POS_W-1:0] * scale;

    always_ff @(posedge aclk) begin
        if (ctl.load_diff) begin
            diff_reg <= DIFF_W'(pos) - DIFF_W'(origin);
        end
        if (ctl.load_mul) begin
            quo_reg <= prod[PROD_W-1:SCALE_SH];
            neg_reg <= diff_reg[DIFF_W-1];
        end
    end

    assign outside = neg_reg
                   | (quo_reg >= QUO_W'(used))
                   | (quo_reg >= QUO_W'(MAX_BINS));
    assign bin     = quo_reg[IDX_W-1:0];

endmodule

// ----- rtl/core/position_grid_histogram_unit.sv -----
// ---------------------------------------------------------------------------
// position_grid_histogram_unit
// two-dimensional particle position histogram held in one counter memory
// ---------------------------------------------------------------------------
//  channel   ports                                   role
//  s_        mode lon lat alive read_x read_y        add / read / read-clear
//  m_        status bin_x bin_y count                one result per input
//  cfg_      wr_en index wdata                       origins, scales, bins used
//
//  a living add passes through subtract, multiply, memory read and update
//  before its result shows; dead adds and reads skip the multiply.
//  one item is in flight: the next accept comes the cycle after the update step.
//  after reset a clearing pass zeroes all MAX_BINS_X*MAX_BINS_Y entries of the
//  counter memory (4096 by default), one entry a cycle, with s_ready held low.
//  a result waiting on m_ready stalls only the update step; the next input
//  transaction is taken as soon as the previous item reached the update step
//  and left it.
// ---------------------------------------------------------------------------
`include "position_grid_histogram_unit_defines.svh"

module position_grid_histogram_unit #(
    parameter int MAX_BINS_X = pgh_pkg::DEF_MAX_BINS_X,
    parameter int MAX_BINS_Y = pgh_pkg::DEF_MAX_BINS_Y,
    parameter int COUNT_BITS = pgh_pkg::DEF_COUNT_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [pgh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pgh_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input transactions
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pgh_pkg::MODE_W-1:0]          s_mode,
    input  logic signed [pgh_pkg::POS_W-1:0]    s_lon,
    input  logic signed [pgh_pkg::POS_W-1:0]    s_lat,
    input  logic                                s_alive,
    input  logic [pgh_pkg::BIN_W-1:0]           s_read_x,
    input  logic [pgh_pkg::BIN_W-1:0]           s_read_y,
    // result transactions
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [pgh_pkg::BIN_W-1:0]           m_bin_x,
    output logic [pgh_pkg::BIN_W-1:0]           m_bin_y,
    output logic [COUNT_BITS-1:0]               m_count
);
    import pgh_pkg::*;

    localparam int DEPTH = MAX_BINS_X * MAX_BINS_Y;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
    localparam int YW    = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
    localparam int RCW   = 32;  // compare width for read indexes

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MUL   = 6'b000100,
        S_LOOK  = 6'b001000,
        S_UPD   = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [POS_W-1:0] lon_origin_reg, lat_origin_reg;
    logic [SCALE_W-1:0]      lon_scale_reg, lat_scale_reg;
    logic [USED_W-1:0]       x_used_reg, y_used_reg;

    // accepted transaction
    mode_t             mode_reg;
    logic              alive_reg;
    logic [BIN_W-1:0]  rx_reg, ry_reg;

    // lookup results carried into the update step
    status_t           res_status_reg;
    logic [BIN_W-1:0]  res_bx_reg, res_by_reg;
    logic [AW-1:0]     addr_reg;
    logic              op_mem_reg, op_inc_reg, op_clr_reg;

    // counter memory
    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic [AW-1:0]         clr_addr_reg;

    // output register
    logic                  m_valid_reg;
    status_t               m_status_reg;
    logic [BIN_W-1:0]      m_bin_x_reg, m_bin_y_reg;
    logic [COUNT_BITS-1:0] m_count_reg;

    // axis interface
    axis_ctl_t   axis_ctl;
    logic        x_out, y_out;
    logic [XW-1:0] x_bin;
    logic [YW-1:0] y_bin;

    logic accept, out_free, commit;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == S_UPD) && out_free;

    // ---------------------------------------------------------------------
    // configuration writes, unknown indexes fall through
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lon_origin_reg <= RST_LON_ORIGIN;
            lat_origin_reg <= RST_LAT_ORIGIN;
            lon_scale_reg  <= RST_LON_SCALE;
            lat_scale_reg  <= RST_LAT_SCALE;
            x_used_reg     <= RST_X_USED;
            y_used_reg     <= RST_Y_USED;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LON_ORIGIN: lon_origin_reg <= cfg_wdata[POS_W-1:0];
                CFG_LAT_ORIGIN: lat_origin_reg <= cfg_wdata[POS_W-1:0];
                CFG_LON_SCALE:  lon_scale_reg  <= cfg_wdata[SCALE_W-1:0];
                CFG_LAT_SCALE:  lat_scale_reg  <= cfg_wdata[SCALE_W-1:0];
                CFG_X_USED:     x_used_reg     <= cfg_wdata[USED_W-1:0];
                CFG_Y_USED:     y_used_reg     <= cfg_wdata[USED_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // binning, one unit per axis; difference taken at accept
    // ---------------------------------------------------------------------
    assign axis_ctl.load_diff = accept;
    assign axis_ctl.load_mul  = (state_reg == S_MUL);

    pgh_axis #(.MAX_BINS(MAX_BINS_X)) u_axis_x (
        .aclk    (aclk),
        .ctl     (axis_ctl),
        .pos     (s_lon),
        .origin  (lon_origin_reg),
        .scale   (lon_scale_reg),
        .used    (x_used_reg),
        .outside (x_out),
        .bin     (x_bin)
    );

    pgh_axis #(.MAX_BINS(MAX_BINS_Y)) u_axis_y (
        .aclk    (aclk),
        .ctl     (axis_ctl),
        .pos     (s_lat),
        .origin  (lat_origin_reg),
        .scale   (lat_scale_reg),
        .used    (y_used_reg),
        .outside (y_out),
        .bin     (y_bin)
    );

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_addr_reg == AW'(DEPTH - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    // only a living add needs the multiply step
                    if (s_mode == MODE_ADD && s_alive) state_next = S_MUL;
                    else                                state_next = S_LOOK;
                end
            end
            S_MUL:   state_next = S_LOOK;
            S_LOOK:  state_next = S_UPD;
            S_UPD: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // capture the transaction fields the later steps need
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= s_mode;
            alive_reg <= s_alive;
            rx_reg    <= s_read_x;
            ry_reg    <= s_read_y;
        end
    end

    // ---------------------------------------------------------------------
    // lookup: classify, form the address, issue the memory read
    // ---------------------------------------------------------------------
    logic          is_add, rd_in_range, look_mem, look_inc, look_clr;
    status_t       look_status;
    logic [BIN_W-1:0] look_bx, look_by;
    logic [XW-1:0] ax;
    logic [YW-1:0] ay;
    logic [AW-1:0] look_addr;

    always_comb begin
        is_add      = (mode_reg == MODE_ADD);
        rd_in_range = (RCW'(rx_reg) < RCW'(MAX_BINS_X)) && (RCW'(ry_reg) < RCW'(MAX_BINS_Y));
        look_mem    = 1'b0;
        look_inc    = 1'b0;
        look_clr    = 1'b0;
        look_bx     = '0;
        look_by     = '0;
        ax          = XW'(rx_reg);
        ay          = YW'(ry_reg);
        if (is_add) begin
            ax = x_bin;
            ay = y_bin;
            if (!alive_reg) begin
                look_status = ST_DEAD;
            end else if (x_out || y_out) begin
                look_status = ST_OUTSIDE;
            end else begin
                look_status = ST_COUNTED;
                look_bx     = BIN_W'(x_bin);
                look_by     = BIN_W'(y_bin);
                look_mem    = 1'b1;
                look_inc    = 1'b1;
            end
        end else begin
            // mode three behaves as a plain read
            look_status = ST_READ;
            look_bx     = rx_reg;
            look_by     = ry_reg;
            look_mem    = rd_in_range;
            look_clr    = rd_in_range && (mode_reg == MODE_READ_CLEAR);
        end
        look_addr = AW'(ax) * AW'(MAX_BINS_Y) + AW'(ay);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_LOOK) begin
            res_status_reg <= look_status;
            res_bx_reg     <= look_bx;
            res_by_reg     <= look_by;
            addr_reg       <= look_addr;
            op_mem_reg     <= look_mem;
            op_inc_reg     <= look_inc;
            op_clr_reg     <= look_clr;
        end
    end

    // ---------------------------------------------------------------------
    // counter memory: registered read, single write port shared by the
    // clearing pass and the update step
    // ---------------------------------------------------------------------
    logic [COUNT_BITS-1:0] inc_val, upd_wdata, mem_wdata;
    logic [AW-1:0]         mem_waddr;
    logic                  mem_we;

    // saturating increment
    assign inc_val   = (rdata_reg == {COUNT_BITS{1'b1}}) ? rdata_reg
                                                         : rdata_reg + COUNT_BITS'(1);
    assign upd_wdata = op_clr_reg ? '0 : inc_val;

    always_comb begin
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = commit && (op_inc_reg || op_clr_reg);
            mem_waddr = addr_reg;
            mem_wdata = upd_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (state_reg == S_LOOK && look_mem) rdata_reg <= mem[look_addr];
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_status_reg <= res_status_reg;
            m_bin_x_reg  <= res_bx_reg;
            m_bin_y_reg  <= res_by_reg;
            if (!op_mem_reg)     m_count_reg <= '0;
            else if (op_inc_reg) m_count_reg <= inc_val;
            else                 m_count_reg <= rdata_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_bin_x  = m_bin_x_reg;
    assign m_bin_y  = m_bin_y_reg;
    assign m_count  = m_count_reg;

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------
    `PGH_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready,
        "input taken while an item is still in flight")
    `PGH_ASSERT_NEXT(a_commit_shows, commit, m_valid,
        "update step finished without presenting a result")
    `PGH_ASSERT_SAME(a_counted_nonzero, m_valid && m_status == ST_COUNTED, m_count != '0,
        "counted bin reports a zero count")
    `PGH_ASSERT_SAME(a_skip_zero,
        m_valid && (m_status == ST_DEAD || m_status == ST_OUTSIDE),
        m_bin_x == '0 && m_bin_y == '0 && m_count == '0,
        "skipped particle carries nonzero result fields")

endmodule
